// ===== src/tts_pkg.sv =====
package tts_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam logic [2:0] MODE_ATTACH     = 3'd0;
    localparam logic [2:0] MODE_DETACH     = 3'd1;
    localparam logic [2:0] MODE_DETACH_ALL = 3'd2;
    localparam logic [2:0] MODE_TICK       = 3'd3;
    localparam logic [2:0] MODE_EXECUTE    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_IDLE    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_REPORT
    } ctl_state_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] period;
        logic [15:0] delay;
        logic [15:0] timer;
        logic        ready;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic report;
    } ctl_cmd_t;

endpackage

// ===== src/tick_task_scheduler.sv =====
// Channel   Direction  Handshake          Payload
// command   in         start, busy        mode, task_id, period, start_delay
// result    out        strobe             status, ready_id, ready_valid, last
//
// An item is taken when start is high and busy is low. Attach, detach, tick and
// execute walk the n live entries through the table memory at one entry per cycle,
// so busy stays high through the sweep, a drain state and a report state; other
// items, any item on an empty table and an attach to a full table keep busy high
// for the report state only. The last result is strobed in the first cycle that
// busy is low. Reset empties the table; the receiver cannot stall the results.
module tick_task_scheduler #(
    parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [7:0]  task_id,
    input  logic [15:0] period,
    input  logic [15:0] start_delay,
    output logic        strobe,
    output logic [1:0]  status,
    output logic [7:0]  ready_id,
    output logic        ready_valid,
    output logic        last
);
    import tts_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    ctl_cmd_t      cmd;
    logic [IW-1:0] rd_addr;
    logic [CW-1:0] count;

    tts_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .IW        (IW),
        .CW        (CW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .mode    (mode),
        .count   (count),
        .busy    (busy),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    tts_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .IW        (IW),
        .CW        (CW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .mode        (mode),
        .task_id     (task_id),
        .period      (period),
        .start_delay (start_delay),
        .count       (count),
        .strobe      (strobe),
        .status      (status),
        .ready_id    (ready_id),
        .ready_valid (ready_valid),
        .last        (last)
    );

endmodule

// ===== src/tts_ctrl.sv =====
module tts_ctrl #(
    parameter int MAX_TASKS = 16,
    parameter int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    parameter int CW = $clog2(MAX_TASKS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0]       mode,
    input  logic [CW-1:0]    count,
    output logic             busy,
    output tts_pkg::ctl_cmd_t cmd,
    output logic [IW-1:0]    rd_addr
);
    import tts_pkg::*;

    ctl_state_t    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          down_reg, down_next;
    logic          accept;
    logic          empty;
    logic          full;
    logic          sweep_last;

    assign accept = start && (state_reg == S_IDLE);
    assign empty  = (count == '0);
    assign full   = (count == CW'(MAX_TASKS));
    // An attach walks the table from the back so that every entry moves up by one.
    assign sweep_last = down_reg ? (idx_reg == '0)
                                 : ((CW'(idx_reg) + CW'(1)) == count);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        down_next  = down_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_REPORT;
                    case (mode)
                        MODE_ATTACH:
                        begin
                            if (!full && !empty)
                            begin
                                state_next = S_SWEEP;
                                idx_next   = IW'(count - CW'(1));
                                down_next  = 1'b1;
                            end
                        end
                        MODE_DETACH, MODE_TICK, MODE_EXECUTE:
                        begin
                            if (!empty)
                            begin
                                state_next = S_SWEEP;
                                idx_next   = '0;
                                down_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = S_REPORT;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = S_DRAIN;
                end
                else if (down_reg)
                begin
                    idx_next = idx_reg - IW'(1);
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.accept = accept;
        cmd.rd_en  = 1'b0;
        cmd.report = 1'b0;
        busy       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
            end
            S_SWEEP:
            begin
                cmd.rd_en = 1'b1;
            end
            S_DRAIN:
            begin
                busy = 1'b1;
            end
            S_REPORT:
            begin
                cmd.report = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign rd_addr = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            down_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            down_reg  <= down_next;
        end
    end

endmodule

// ===== src/tts_datapath.sv =====
module tts_datapath #(
    parameter int MAX_TASKS = 16,
    parameter int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    parameter int CW = $clog2(MAX_TASKS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tts_pkg::ctl_cmd_t cmd,
    input  logic [IW-1:0]     rd_addr,
    input  logic [2:0]        mode,
    input  logic [7:0]        task_id,
    input  logic [15:0]       period,
    input  logic [15:0]       start_delay,
    output logic [CW-1:0]     count,
    output logic              strobe,
    output logic [1:0]        status,
    output logic [7:0]        ready_id,
    output logic              ready_valid,
    output logic              last
);
    import tts_pkg::*;

    entry_t        mem [MAX_TASKS];

    logic [2:0]    mode_reg;
    logic [7:0]    id_reg;
    logic [15:0]   per_reg;
    logic [15:0]   dly_reg;

    entry_t        rd_data_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_valid_reg;

    logic [CW-1:0] count_reg, count_next;
    logic          found_reg, found_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_id_reg, pend_id_next;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    entry_t        upd;

    logic          out_load;
    logic [1:0]    out_status;
    logic [7:0]    out_id;
    logic          out_valid;
    logic          out_last;

    logic          strobe_reg;
    logic [1:0]    status_reg;
    logic [7:0]    ready_id_reg;
    logic          ready_valid_reg;
    logic          last_reg;

    always_comb
    begin
        wr_en           = 1'b0;
        wr_addr         = rd_idx_reg;
        wr_data         = rd_data_reg;
        upd             = rd_data_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_load        = 1'b0;
        out_status      = ST_OK;
        out_id          = '0;
        out_valid       = 1'b0;
        out_last        = 1'b1;

        // Second half of the sweep: the entry read in the previous cycle.
        if (rd_valid_reg)
        begin
            case (mode_reg)
                MODE_ATTACH:
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg + IW'(1);
                end
                MODE_DETACH:
                begin
                    // Once the victim is found, each later entry closes the gap.
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = rd_idx_reg - IW'(1);
                    end
                    else if (rd_data_reg.id == id_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
                MODE_TICK:
                begin
                    if (rd_data_reg.delay != '0)
                    begin
                        upd.delay = rd_data_reg.delay - 16'd1;
                    end
                    else if (rd_data_reg.timer != '0)
                    begin
                        upd.timer = rd_data_reg.timer - 16'd1;
                        if (rd_data_reg.timer == 16'd1)
                        begin
                            upd.ready = 1'b1;
                        end
                    end
                    wr_en   = 1'b1;
                    wr_data = upd;
                end
                MODE_EXECUTE:
                begin
                    // A ready id is held back one step so the final one can carry last.
                    if (rd_data_reg.ready)
                    begin
                        upd.ready = 1'b0;
                        upd.timer = rd_data_reg.period;
                        wr_en     = 1'b1;
                        wr_data   = upd;
                        if (pend_valid_reg)
                        begin
                            out_load  = 1'b1;
                            out_id    = pend_id_reg;
                            out_valid = 1'b1;
                            out_last  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = rd_data_reg.id;
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end

        if (cmd.report)
        begin
            out_load = 1'b1;
            case (mode_reg)
                MODE_ATTACH:
                begin
                    if (count_reg == CW'(MAX_TASKS))
                    begin
                        out_status = ST_FULL;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_data.id    = id_reg;
                        wr_data.period = per_reg;
                        wr_data.delay = dly_reg;
                        wr_data.timer = per_reg;
                        wr_data.ready = 1'b0;
                        count_next    = count_reg + CW'(1);
                    end
                end
                MODE_DETACH:
                begin
                    if (found_reg)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        out_status = ST_MISSING;
                    end
                end
                MODE_DETACH_ALL:
                begin
                    count_next = '0;
                end
                MODE_EXECUTE:
                begin
                    if (pend_valid_reg)
                    begin
                        out_id    = pend_id_reg;
                        out_valid = 1'b1;
                    end
                    else
                    begin
                        out_status = ST_IDLE;
                    end
                end
                default:
                begin
                    out_status = ST_OK;
                end
            endcase
        end

        if (cmd.accept)
        begin
            found_next      = 1'b0;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= mode;
            id_reg   <= task_id;
            per_reg  <= period;
            dly_reg  <= start_delay;
        end
        pend_id_reg <= pend_id_next;
        if (out_load)
        begin
            status_reg      <= out_status;
            ready_id_reg    <= out_id;
            ready_valid_reg <= out_valid;
            last_reg        <= out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            count_reg      <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.rd_en;
            count_reg      <= count_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= out_load;
        end
    end

    assign count       = count_reg;
    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign ready_id    = ready_id_reg;
    assign ready_valid = ready_valid_reg;
    assign last        = last_reg;

endmodule

// ===== src/tts_checker.sv =====
module tts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        strobe,
    input logic [1:0]  status,
    input logic        ready_valid,
    input logic        last
);
    import tts_pkg::*;

    // Every accepted item makes busy rise in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted item");

    // Results only appear while an item is in work or as it finishes.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy || $past(busy))
        else $error("result strobed with no item in work");

    // More results of the same item follow, so the block must still be busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("item finished without its last result");

    // A task id is only given with an ok status; other results are single.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && ready_valid |-> status == ST_OK)
        else $error("ready id given with an error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !ready_valid |-> last)
        else $error("result without a task id was not the last one");

endmodule

bind tick_task_scheduler tts_checker u_tts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .strobe      (strobe),
    .status      (status),
    .ready_valid (ready_valid),
    .last        (last)
);
